@@ rtl/core/ctt_pkg.sv @@
// ============================================================================
// ctt_pkg: shared definitions for the configuration text tokenizer
// Holds token kinds, character codes, sizes and the result beat record.
// ============================================================================
package ctt_pkg;

    // Sizes
    localparam int MAX_ID_LEN = 64;
    localparam int POS_WIDTH  = 16;
    localparam int KIND_W     = 4;
    localparam int CHAR_W     = 8;
    localparam int POS_OUT_W  = 16;
    localparam int LEN_W      = 7;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_IDENT_CHAR = 4'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT_END  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_EQUALS     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_LBRACE     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_RBRACE     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LANGLE     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RANGLE     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_COMMA      = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ERROR      = 4'd8;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH       = 8'h23;
    localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_LANGLE     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQUALS     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_RANGLE     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LBRACE     = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE     = 8'h7D;

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [CHAR_W-1:0]    char_value;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] column;
        logic [LEN_W-1:0]     ident_length;
        logic                 run_last;
    } result_t;

endpackage

@@ rtl/core/config_text_tokenizer.sv @@
// ============================================================================
// config_text_tokenizer: byte-serial tokenizer for configuration text
// Classifies each source byte, tracks row and column and emits tokens.
// ============================================================================
//
// Usage
//   Input channel (in_valid / in_ready): one source byte per beat, with
//   end_of_text set on the final byte of a source. Output channel
//   (out_valid / out_ready): one token per beat; run_last marks the last
//   token caused by a byte. A byte causes zero, one or two tokens.
//   Tokens are registered into the result queue and offered from its head.
//   Throughput: one byte per cycle while each byte gives at most one token
//   and the receiver keeps up; the tokens of a two-token byte leave one at
//   a time, as the rate is set by the single read port of the four-entry
//   result queue. in_ready is high while the queue has at least two free
//   entries, so when the receiver stalls the queue fills and input stalls with it.
//   After an error token every byte is accepted and dropped until reset.
//   Reset empties the queue and returns to row 1, column 0, idle scan.
//   End of text returns to that same start state for the next source.
//
module config_text_tokenizer
    import ctt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAR_W-1:0]    text_byte,
    input  logic                 end_of_text,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KIND_W-1:0]    kind,
    output logic [CHAR_W-1:0]    char_value,
    output logic [POS_OUT_W-1:0] row,
    output logic [POS_OUT_W-1:0] column,
    output logic [LEN_W-1:0]     ident_length,
    output logic                 run_last
);

    // Scan modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_IDENT   = 2'd1;
    localparam logic [1:0] MODE_COMMENT = 2'd2;
    localparam logic [1:0] MODE_HALT    = 2'd3;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [LEN_W-1:0]     LEN_MAX = LEN_W'(MAX_ID_LEN);

    // Saturating position step
    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    // Low bits of a position for the output fields
    function automatic logic [POS_OUT_W-1:0] pos_out(input logic [POS_WIDTH-1:0] p);
        logic [POS_WIDTH+POS_OUT_W-1:0] wide;
        wide = {{POS_OUT_W{1'b0}}, p};
        return wide[POS_OUT_W-1:0];
    endfunction

    function automatic logic is_word(input logic [CHAR_W-1:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDERSCORE);
    endfunction

    // Scanner state
    logic [1:0]           mode_reg,      mode_next;
    logic [POS_WIDTH-1:0] cur_row_reg,   cur_row_next;
    logic [POS_WIDTH-1:0] cur_col_reg,   cur_col_next;
    logic [POS_WIDTH-1:0] start_row_reg, start_row_next;
    logic [POS_WIDTH-1:0] start_col_reg, start_col_next;
    logic [LEN_W-1:0]     id_count_reg,  id_count_next;

    // Result queue
    result_t    queue_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg,  count_next;

    logic       push;
    logic       pop;
    result_t    res [2];
    logic [1:0] res_n;
    logic       word;
    logic       is_lf;
    logic [KIND_W-1:0] punct_kind;

    assign in_ready = (count_reg <= 3'd2);
    assign push     = in_valid && in_ready;
    assign out_valid = (count_reg != 3'd0);
    assign pop      = out_valid && out_ready;

    assign word  = is_word(text_byte);
    assign is_lf = (text_byte == CH_LF);

    // Classify the byte, build its tokens and the next scanner state
    always_comb
    begin
        mode_next      = mode_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        start_row_next = start_row_reg;
        start_col_next = start_col_reg;
        id_count_next  = id_count_reg;
        res[0]         = '0;
        res[1]         = '0;
        res_n          = 2'd0;
        punct_kind     = KIND_ERROR;

        if (mode_reg != MODE_HALT)
        begin
            // advance the position
            if (is_lf)
            begin
                cur_row_next = sat_inc(cur_row_reg);
                cur_col_next = '0;
            end
            else
            begin
                cur_col_next = sat_inc(cur_col_reg);
            end

            if (mode_reg == MODE_COMMENT)
            begin
                if (is_lf)
                    mode_next = MODE_IDLE;
            end
            else if (mode_reg == MODE_IDENT && word)
            begin
                if (id_count_reg < LEN_MAX)
                    id_count_next = id_count_reg + 1'b1;
                res[res_n[0]] = '{KIND_IDENT_CHAR, text_byte, pos_out(start_row_reg),
                                  pos_out(start_col_reg), '0, 1'b0};
                res_n = res_n + 1'b1;
            end
            else
            begin
                // close the running identifier
                if (mode_reg == MODE_IDENT)
                begin
                    res[res_n[0]] = '{KIND_IDENT_END, text_byte, pos_out(start_row_reg),
                                      pos_out(start_col_reg), id_count_reg, 1'b0};
                    res_n = res_n + 1'b1;
                    mode_next = MODE_IDLE;
                end

                // handle the byte as in idle scan
                if (text_byte == CH_SPACE || text_byte == CH_TAB || is_lf)
                begin
                    // skip whitespace
                end
                else if (text_byte == CH_HASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (word)
                begin
                    mode_next      = MODE_IDENT;
                    start_row_next = cur_row_next;
                    start_col_next = cur_col_next;
                    id_count_next  = LEN_W'(1);
                    res[res_n[0]] = '{KIND_IDENT_CHAR, text_byte, pos_out(cur_row_next),
                                      pos_out(cur_col_next), '0, 1'b0};
                    res_n = res_n + 1'b1;
                end
                else
                begin
                    case (text_byte)
                        CH_EQUALS: punct_kind = KIND_EQUALS;
                        CH_LBRACE: punct_kind = KIND_LBRACE;
                        CH_RBRACE: punct_kind = KIND_RBRACE;
                        CH_LANGLE: punct_kind = KIND_LANGLE;
                        CH_RANGLE: punct_kind = KIND_RANGLE;
                        CH_COMMA:  punct_kind = KIND_COMMA;
                        default:   punct_kind = KIND_ERROR;
                    endcase
                    if (punct_kind == KIND_ERROR)
                        mode_next = MODE_HALT;
                    res[res_n[0]] = '{punct_kind, text_byte, pos_out(cur_row_next),
                                      pos_out(cur_col_next), '0, 1'b0};
                    res_n = res_n + 1'b1;
                end
            end

            // end of text flushes an open identifier and rewinds
            if (end_of_text && mode_next == MODE_IDENT)
            begin
                res[res_n[0]] = '{KIND_IDENT_END, text_byte, pos_out(start_row_next),
                                  pos_out(start_col_next), id_count_next, 1'b0};
                res_n = res_n + 1'b1;
            end
            if (end_of_text && mode_next != MODE_HALT)
            begin
                mode_next     = MODE_IDLE;
                cur_row_next  = POS_WIDTH'(1);
                cur_col_next  = '0;
                id_count_next = '0;
            end

            // mark the last token of this byte
            if (res_n == 2'd2)
                res[1].run_last = 1'b1;
            else if (res_n == 2'd1)
                res[0].run_last = 1'b1;
        end
    end

    // Queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + res_n;
            count_next  = count_next + {1'b0, res_n};
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            count_next  = count_next - 3'd1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            cur_row_reg   <= POS_WIDTH'(1);
            cur_col_reg   <= '0;
            start_row_reg <= '0;
            start_col_reg <= '0;
            id_count_reg  <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (push)
            begin
                mode_reg      <= mode_next;
                cur_row_reg   <= cur_row_next;
                cur_col_reg   <= cur_col_next;
                start_row_reg <= start_row_next;
                start_col_reg <= start_col_next;
                id_count_reg  <= id_count_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the tokens of an accepted beat into the queue
    always_ff @(posedge clk)
    begin
        if (push && res_n != 2'd0)
            queue_reg[wr_ptr_reg] <= res[0];
        if (push && res_n == 2'd2)
            queue_reg[wr_ptr_reg + 2'd1] <= res[1];
    end

    // Present the head of the queue
    assign kind         = queue_reg[rd_ptr_reg].kind;
    assign char_value   = queue_reg[rd_ptr_reg].char_value;
    assign row          = queue_reg[rd_ptr_reg].row;
    assign column       = queue_reg[rd_ptr_reg].column;
    assign ident_length = queue_reg[rd_ptr_reg].ident_length;
    assign run_last     = queue_reg[rd_ptr_reg].run_last;

endmodule

@@ rtl/core/ctt_checker.sv @@
// ============================================================================
// ctt_checker: port-level checks for the configuration text tokenizer
// Watches the output channel and the token fields over time.
// ============================================================================
module ctt_checker
    import ctt_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [KIND_W-1:0]    kind,
    input logic [CHAR_W-1:0]    char_value,
    input logic [POS_OUT_W-1:0] row,
    input logic [LEN_W-1:0]     ident_length,
    input logic                 run_last
);

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_value)
            && $stable(ident_length) && $stable(run_last))
        else $error("stalled output beat changed");

    // Only an identifier end carries a length
    a_len_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_IDENT_END |-> ident_length == '0)
        else $error("length on a token other than identifier end");

    // Identifier length stays within its saturation bound
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_IDENT_END |->
            ident_length != '0 && ident_length <= LEN_W'(MAX_ID_LEN))
        else $error("identifier length out of range");

    // Error always closes its byte's run, and the row is never zero
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> run_last && row != '0)
        else $error("error token not last of its byte");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (.*);
